// ===== sv/sine_window_oscillator_core_assert.svh =====
// Assertion macros for the sine window oscillator RTL.
// Needs nothing else; the bodies are empty when SYNTHESIS is defined.
`ifndef SINE_WINDOW_OSCILLATOR_CORE_ASSERT_SVH
`define SINE_WINDOW_OSCILLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold on every clock edge out of reset
`define SWO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// condition that must hold in the cycle after a trigger
`define SWO_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define SWO_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWO_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif
`endif

// ===== sv/swo_pkg.sv =====
// Package for the sine window oscillator: widths, codes, reset constants and
// the structs passed between its modules. Depends on nothing.
package swo_pkg;

    localparam int MAX_QUADS     = 255;
    localparam int OSC_FRAC_BITS = 30;

    localparam int SAMPLE_W   = 16;
    localparam int OSC_W      = 32;
    localparam int WGT_W      = OSC_W + 2;
    localparam int TYPE_W     = 2;
    localparam int QCFG_W     = 8;
    localparam int QUAD_W     = $clog2(MAX_QUADS + 1);
    localparam int QEXT_W     = (QUAD_W > QCFG_W) ? QUAD_W : QCFG_W;
    localparam int POS_W      = $clog2(4 * MAX_QUADS);
    localparam int LEN_W      = QUAD_W + 2;
    localparam int FREQ_W     = OSC_FRAC_BITS + 2;
    localparam int COEFF_W    = OSC_FRAC_BITS + 2;
    localparam int DIV_W      = OSC_FRAC_BITS + 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_QUADS = CFG_IDX_W'(1);

    // window types; the unused code behaves as the falling quarter
    localparam logic [TYPE_W-1:0] WT_FULL    = TYPE_W'(0);
    localparam logic [TYPE_W-1:0] WT_RISING  = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] WT_FALLING = TYPE_W'(2);

    localparam logic [TYPE_W-1:0] RESET_TYPE  = WT_FULL;
    localparam logic [QCFG_W-1:0] RESET_QUADS = QCFG_W'(80);

    // pi in Q.F, rounded from a Q62 value
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI_F =
        (PI_Q62 + (64'd1 << (61 - OSC_FRAC_BITS))) >> (62 - OSC_FRAC_BITS);

    // frequency and coefficient for the reset configuration
    localparam logic [63:0] RESET_LEN1  = 64'd4 * 64'(RESET_QUADS) + 64'd1;
    localparam logic [63:0] RESET_NUM   = (RESET_TYPE == WT_FULL) ? (PI_F << 1) : PI_F;
    localparam logic [63:0] RESET_FREQ  = (RESET_NUM + RESET_LEN1 / 64'd2) / RESET_LEN1;
    localparam logic [63:0] RESET_FSQ   =
        (RESET_FREQ * RESET_FREQ + (64'd1 << (OSC_FRAC_BITS - 1))) >> OSC_FRAC_BITS;
    localparam logic [63:0] RESET_COEFF = (64'd2 << OSC_FRAC_BITS) - RESET_FSQ;

    localparam logic signed [OSC_W-1:0] OSC_ONE = OSC_W'(64'd1 << OSC_FRAC_BITS);
    localparam logic signed [OSC_W-1:0] OSC_MAX = {1'b0, {(OSC_W-1){1'b1}}};
    localparam logic signed [OSC_W-1:0] OSC_MIN = {1'b1, {(OSC_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic RESET_RISING = (RESET_TYPE == WT_FULL) || (RESET_TYPE == WT_RISING);
    localparam logic signed [OSC_W-1:0] RESET_PREV =
        RESET_RISING ? OSC_W'(0) : OSC_ONE;
    localparam logic signed [OSC_W-1:0] RESET_CURR =
        RESET_RISING ? OSC_W'(RESET_FREQ) : OSC_W'((RESET_COEFF + 64'd1) >> 1);

    // window settings and control from the configuration side
    typedef struct packed {
        logic [TYPE_W-1:0]  wtype;
        logic [FREQ_W-1:0]  freq;
        logic [COEFF_W-1:0] coeff;
        logic [POS_W-1:0]   last_pos;
        logic               load;
        logic               busy;
    } swo_window_t;

    // request held between the oscillator stage and the output stage
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [WGT_W-1:0]    weight;
        logic                       last;
    } swo_stage_t;

endpackage

// ===== sv/swo_div.sv =====
// Restoring divider, one quotient bit per cycle, for the window frequency.
// Depends on swo_pkg.
module swo_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [swo_pkg::DIV_W-1:0]  dividend,
    input  logic [swo_pkg::LEN_W-1:0]  divisor,
    output logic                       done,
    output logic [swo_pkg::DIV_W-1:0]  quotient
);
    import swo_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [LEN_W:0]   trial;
    logic             fits;
    logic [LEN_W-1:0] rem_next;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
    end

    // control: count the quotient bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/swo_cfg.sv =====
// Configuration registers and the sequencer that works out the oscillator
// frequency and coefficient after a write. Depends on swo_pkg and swo_div.
module swo_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swo_pkg::CFG_DATA_W-1:0] cfg_data,
    output swo_pkg::swo_window_t           win
);
    import swo_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_SQR   = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_FIN   = 6'b100000
    } swo_cfg_state_t;

    swo_cfg_state_t      state_reg, state_next;
    logic [TYPE_W-1:0]   type_reg;
    logic [QCFG_W-1:0]   quads_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic [COEFF_W-1:0]  coeff_reg;
    logic [2*FREQ_W-1:0] sq_reg;

    logic                cfg_take;
    logic                wr_type;
    logic                wr_quads;
    logic [QEXT_W-1:0]   q_ext;
    logic [QEXT_W-1:0]   q_clamp;
    logic [QUAD_W-1:0]   q_eff;
    logic [LEN_W-1:0]    len1;
    logic [DIV_W-1:0]    num;
    logic [DIV_W-1:0]    dividend;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [2*FREQ_W:0]   fsq_rnd;
    logic [COEFF_W-1:0]  coeff_calc;

    // decode the register write
    always_comb begin
        cfg_take = cfg_valid && cfg_ready;
        wr_type  = 1'b0;
        wr_quads = 1'b0;
        unique case (cfg_index)
            REG_WINDOW_TYPE:  wr_type  = cfg_take;
            REG_WINDOW_QUADS: wr_quads = cfg_take;
            default: ;
        endcase
    end

    // clamp the quad count and form the divider operands
    always_comb begin
        q_ext = QEXT_W'(quads_reg);
        if (q_ext == '0) begin
            q_clamp = QEXT_W'(1);
        end else if (q_ext > QEXT_W'(MAX_QUADS)) begin
            q_clamp = QEXT_W'(MAX_QUADS);
        end else begin
            q_clamp = q_ext;
        end
        q_eff    = QUAD_W'(q_clamp);
        len1     = {q_eff, 2'b01};
        num      = (type_reg == WT_FULL) ? DIV_W'(PI_F << 1) : DIV_W'(PI_F);
        dividend = num + DIV_W'({q_eff, 1'b0});
    end

    swo_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_START),
        .dividend (dividend),
        .divisor  (len1),
        .done     (div_done),
        .quotient (div_quo)
    );

    // round the squared frequency and take it from two
    always_comb begin
        fsq_rnd    = (2*FREQ_W+1)'(sq_reg) + (2*FREQ_W+1)'(64'd1 << (OSC_FRAC_BITS - 1));
        coeff_calc = COEFF_W'(64'd2 << OSC_FRAC_BITS) - COEFF_W'(fsq_rnd >> OSC_FRAC_BITS);
    end

    // sequence: divide, square, coefficient, reload the oscillator
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (wr_type || wr_quads) state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_SQR;
            ST_SQR:   state_next = ST_CALC;
            ST_CALC:  state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            type_reg  <= RESET_TYPE;
            quads_reg <= RESET_QUADS;
            freq_reg  <= FREQ_W'(RESET_FREQ);
            coeff_reg <= COEFF_W'(RESET_COEFF);
        end else begin
            state_reg <= state_next;
            if (wr_type) begin
                type_reg <= cfg_data[TYPE_W-1:0];
            end
            if (wr_quads) begin
                quads_reg <= cfg_data[QCFG_W-1:0];
            end
            if (state_reg == ST_DIV && div_done) begin
                freq_reg <= FREQ_W'(div_quo);
            end
            if (state_reg == ST_CALC) begin
                coeff_reg <= coeff_calc;
            end
        end
    end

    // hold the square of the new frequency
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SQR) begin
            sq_reg <= (2*FREQ_W)'(freq_reg) * (2*FREQ_W)'(freq_reg);
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb begin
        win.wtype    = type_reg;
        win.freq     = freq_reg;
        win.coeff    = coeff_reg;
        win.last_pos = POS_W'({q_eff - QUAD_W'(1), 2'b11});
        win.load     = (state_reg == ST_FIN);
        win.busy     = (state_reg != ST_IDLE);
    end

endmodule

// ===== sv/swo_osc.sv =====
// Recursive oscillator, sample position and the input stage register that
// pairs each request with its window weight. Depends on swo_pkg.
`include "sine_window_oscillator_core_assert.svh"
module swo_osc (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  swo_pkg::swo_window_t            win,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [swo_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic                            st_ready,
    output logic                            st_valid,
    output swo_pkg::swo_stage_t             st
);
    import swo_pkg::*;

    localparam int STEP_W = 2 * OSC_W + 2;

    logic signed [OSC_W-1:0]  prev_reg, prev_next;
    logic signed [OSC_W-1:0]  curr_reg, curr_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     st_vld_reg;
    swo_stage_t               st_reg;

    logic                     take;
    logic                     odd;
    logic                     is_last;
    logic                     rising;
    logic [COEFF_W:0]         coeff_inc;
    logic signed [OSC_W-1:0]  start_prev;
    logic signed [OSC_W-1:0]  start_curr;
    logic signed [STEP_W-1:0] step_prod;
    logic signed [STEP_W-1:0] step_rnd;
    logic signed [STEP_W-1:0] step_shf;
    logic signed [STEP_W-1:0] step_diff;
    logic signed [OSC_W-1:0]  step_val;
    logic signed [WGT_W-1:0]  weight;

    assign s_ready  = !win.busy && (!st_vld_reg || st_ready);
    assign take     = s_valid && s_ready;
    assign odd      = pos_reg[0];
    assign is_last  = pos_reg >= win.last_pos;

    // start values of the window
    always_comb begin
        rising     = (win.wtype == WT_FULL) || (win.wtype == WT_RISING);
        coeff_inc  = (COEFF_W+1)'(win.coeff) + (COEFF_W+1)'(1);
        start_prev = rising ? OSC_W'(0) : OSC_ONE;
        start_curr = rising ? OSC_W'(win.freq) : OSC_W'(coeff_inc >> 1);
    end

    // one oscillator step: round(c*curr) - prev, saturated
    always_comb begin
        step_prod = $signed({1'b0, win.coeff}) * curr_reg;
        step_rnd  = step_prod + $signed(STEP_W'(64'd1 << (OSC_FRAC_BITS - 1)));
        step_shf  = step_rnd >>> OSC_FRAC_BITS;
        step_diff = step_shf - STEP_W'(prev_reg);
        if (step_diff > STEP_W'(OSC_MAX)) begin
            step_val = OSC_MAX;
        end else if (step_diff < STEP_W'(OSC_MIN)) begin
            step_val = OSC_MIN;
        end else begin
            step_val = OSC_W'(step_diff);
        end
    end

    // even positions: sum of both values; odd: the newer value, doubled
    assign weight = odd ? (WGT_W'(curr_reg) <<< 1) : (WGT_W'(prev_reg) + WGT_W'(curr_reg));

    // advance the oscillator after an odd position, reload on restart
    always_comb begin
        prev_next = prev_reg;
        curr_next = curr_reg;
        pos_next  = pos_reg;
        if (win.load || (take && is_last)) begin
            prev_next = start_prev;
            curr_next = start_curr;
            pos_next  = '0;
        end else if (take) begin
            pos_next = pos_reg + POS_W'(1);
            if (odd) begin
                prev_next = curr_reg;
                curr_next = step_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= RESET_PREV;
            curr_reg   <= RESET_CURR;
            pos_reg    <= '0;
            st_vld_reg <= 1'b0;
        end else begin
            prev_reg <= prev_next;
            curr_reg <= curr_next;
            pos_reg  <= pos_next;
            if (take) begin
                st_vld_reg <= 1'b1;
            end else if (st_ready) begin
                st_vld_reg <= 1'b0;
            end
        end
    end

    // capture the request with its weight
    always_ff @(posedge aclk) begin
        if (take) begin
            st_reg.sample <= s_sample_in;
            st_reg.weight <= weight;
            st_reg.last   <= is_last;
        end
    end

    assign st_valid = st_vld_reg;
    assign st       = st_reg;

    `SWO_ASSERT(a_pos_in_window, aclk, aresetn, win.busy || (pos_reg <= win.last_pos), "sample position beyond end of window")
    `SWO_ASSERT_NEXT(a_load_clears_pos, aclk, aresetn, win.load, pos_reg == '0, "window reload did not clear the position")
    `SWO_ASSERT_NEXT(a_osc_shift, aclk, aresetn, take && odd && !is_last, prev_reg == $past(curr_reg), "oscillator did not advance after odd position")

endmodule

// ===== sv/swo_out.sv =====
// Output stage: sample times weight, rounded, saturated and registered.
// Depends on swo_pkg.
module swo_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                st_valid,
    output logic                                st_ready,
    input  swo_pkg::swo_stage_t                 st,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [swo_pkg::SAMPLE_W-1:0] m_windowed_sample,
    output logic                                m_window_last
);
    import swo_pkg::*;

    localparam int PROD_W = SAMPLE_W + WGT_W;

    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [PROD_W-1:0]   prod_shf;
    logic signed [SAMPLE_W-1:0] y;
    logic                       m_vld_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       last_reg;
    logic                       load;

    // round half up at bit F+1 and clip to the sample range
    always_comb begin
        prod     = $signed(st.sample) * $signed(st.weight);
        prod_rnd = prod + $signed(PROD_W'(64'd1 << OSC_FRAC_BITS));
        prod_shf = prod_rnd >>> (OSC_FRAC_BITS + 1);
        if (prod_shf > PROD_W'(SAMPLE_MAX)) begin
            y = SAMPLE_MAX;
        end else if (prod_shf < PROD_W'(SAMPLE_MIN)) begin
            y = SAMPLE_MIN;
        end else begin
            y = SAMPLE_W'(prod_shf);
        end
    end

    assign st_ready = !m_vld_reg || m_ready;
    assign load     = st_valid && st_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (load) begin
            m_vld_reg <= 1'b1;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            y_reg    <= y;
            last_reg <= st.last;
        end
    end

    assign m_valid           = m_vld_reg;
    assign m_windowed_sample = y_reg;
    assign m_window_last     = last_reg;

endmodule

// ===== sv/sine_window_oscillator_core.sv =====
// Sine window on a stream of 16-bit signed samples, one request per clock
// while s_ready is high. A sample passes the oscillator stage, which registers
// it with its window weight, and the output stage, which multiplies, rounds,
// saturates and holds the result. The window is 4*window_quads samples long
// (a window_quads of zero counts as one) and restarts by itself after the
// sample flagged window_last. Writing window_type or window_quads restarts
// the window and recomputes the oscillator frequency with a 34-step
// shift-subtract divider followed by a squaring multiply; the block accepts
// no samples until that is done. Depends on swo_pkg, swo_cfg, swo_osc and swo_out.
module sine_window_oscillator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [swo_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [swo_pkg::SAMPLE_W-1:0] m_windowed_sample,
    output logic                                m_window_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swo_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import swo_pkg::*;

    swo_window_t win;
    swo_stage_t  st;
    logic        st_valid;
    logic        st_ready;

    // configuration and coefficient sequencer
    swo_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .win       (win)
    );

    // oscillator and input stage
    swo_osc u_osc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .win         (win),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .st_ready    (st_ready),
        .st_valid    (st_valid),
        .st          (st)
    );

    // multiply and output register
    swo_out u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .st_valid          (st_valid),
        .st_ready          (st_ready),
        .st                (st),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_windowed_sample (m_windowed_sample),
        .m_window_last     (m_window_last)
    );

endmodule

// ===== tb/sv/sine_window_oscillator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sine_window_oscillator_core: drives samples and register writes,
// predicts each windowed sample in step with accepted requests and compares in order.
// Depends on swo_pkg and the core RTL.
module sine_window_oscillator_core_tb;
    import swo_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    // the code that no window type names; it behaves as the falling quarter
    localparam logic [TYPE_W-1:0]    WT_UNUSED  = TYPE_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } window_result_t;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_windowed_sample;
    logic                       m_window_last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // window model state
    logic [TYPE_W-1:0] model_type;
    logic [7:0]        win_quads;
    logic [9:0]        win_pos;
    longint            win_prev;
    longint            win_curr;
    longint            win_coeff;

    window_result_t pending_weighted[$];
    int fail_count    = 0;
    int samples_seen  = 0;
    int window_ends   = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left       = 0;

    sine_window_oscillator_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_in       (s_sample_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_windowed_sample (m_windowed_sample),
        .m_window_last     (m_window_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int unsigned window_quads_used();
        int unsigned q;
        q = 32'(win_quads);
        if (q < 1) q = 1;
        if (q > MAX_QUADS) q = MAX_QUADS;
        return q;
    endfunction

    // work out frequency and coefficient, then reload the oscillator at window start
    function automatic void restart_window();
        logic [63:0] len1, num, freq, fsq, c;
        len1 = 64'd4 * 64'(window_quads_used()) + 64'd1;
        num  = (model_type == WT_FULL) ? (PI_F << 1) : PI_F;
        freq = (num + len1 / 64'd2) / len1;
        fsq  = (freq * freq + (64'd1 << (OSC_FRAC_BITS - 1))) >> OSC_FRAC_BITS;
        c    = (64'd2 << OSC_FRAC_BITS) - fsq;
        win_coeff = longint'(c);
        if (model_type == WT_FULL || model_type == WT_RISING) begin
            win_prev = 0;
            win_curr = longint'(freq);
        end else begin
            win_prev = longint'(64'd1 << OSC_FRAC_BITS);
            win_curr = longint'((c + 64'd1) >> 1);
        end
        win_pos = '0;
    endfunction

    function automatic void store_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        if (idx == REG_WINDOW_TYPE) begin
            model_type = val[TYPE_W-1:0];
            restart_window();
        end else if (idx == REG_WINDOW_QUADS) begin
            win_quads = val;
            restart_window();
        end
    endfunction

    // weight one sample and advance the window by one position
    function automatic window_result_t window_sample(logic signed [SAMPLE_W-1:0] smp);
        window_result_t r;
        longint x, y, nxt;
        logic [9:0] last_pos;
        x = longint'(smp);
        last_pos = 10'(4 * window_quads_used() - 1);
        r.last = (win_pos >= last_pos);
        if (!win_pos[0])
            y = (x * (win_prev + win_curr) + (longint'(1) << OSC_FRAC_BITS))
                >>> (OSC_FRAC_BITS + 1);
        else
            y = (x * win_curr + (longint'(1) << (OSC_FRAC_BITS - 1))) >>> OSC_FRAC_BITS;
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        r.sample = SAMPLE_W'(y);
        // step the oscillator after each odd position
        if (win_pos[0]) begin
            nxt = ((win_coeff * win_curr + (longint'(1) << (OSC_FRAC_BITS - 1)))
                   >>> OSC_FRAC_BITS) - win_prev;
            if (nxt < longint'(OSC_MIN)) nxt = longint'(OSC_MIN);
            if (nxt > longint'(OSC_MAX)) nxt = longint'(OSC_MAX);
            win_prev = win_curr;
            win_curr = nxt;
        end
        if (r.last)
            restart_window();
        else
            win_pos = win_pos + 10'd1;
        return r;
    endfunction

    // track requests on every channel, predict and compare in order
    always @(posedge aclk) begin
        window_result_t want;
        if (!aresetn) begin
            model_type = RESET_TYPE;
            win_quads  = RESET_QUADS;
            restart_window();
            pending_weighted.delete();
            quiet_cycles = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                store_register(cfg_index, cfg_data);
                reg_writes++;
            end
            if (s_valid && s_ready)
                pending_weighted.push_back(window_sample(s_sample_in));
            if (m_valid && m_ready) begin
                samples_seen++;
                if (m_window_last) window_ends++;
                if (pending_weighted.size() == 0) begin
                    $display("%0t: result with none pending: sample %0d last %0b",
                             $time, m_windowed_sample, m_window_last);
                    fail_count++;
                end else begin
                    want = pending_weighted.pop_front();
                    if (m_windowed_sample !== want.sample) begin
                        $display("%0t: windowed_sample expected %0d actual %0d",
                                 $time, want.sample, m_windowed_sample);
                        fail_count++;
                    end
                    if (m_window_last !== want.last) begin
                        $display("%0t: window_last expected %0b actual %0b",
                                 $time, want.last, m_window_last);
                        fail_count++;
                    end
                end
            end
            // give up when nothing moves for too long
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // stall the result channel, switching between patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready <= (rx_left % 4 == 0);
            default:     m_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    function automatic logic signed [SAMPLE_W-1:0] corner_sample(int k);
        case (k % 7)
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return SAMPLE_W'(-1);
            4: return SAMPLE_W'(1);
            5: return SAMPLE_W'(16'h5555);
            default: return SAMPLE_W'(16'hAAAA);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // send one sample request, leaving valid high on return at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic hold_sender();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_weighted.size() != 0) @(negedge aclk);
    endtask

    // present one register write and wait for it, leaving valid high
    task automatic cfg_send(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_send(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] type_val,
                             input logic [CFG_DATA_W-1:0] quads_val);
        wait_drained();
        cfg_send(REG_WINDOW_TYPE, type_val);
        cfg_send(REG_WINDOW_QUADS, quads_val);
        cfg_valid <= 1'b0;
    endtask

    // extremes through the window as it stands after reset
    task automatic test_reset_window();
        gaps_on = 1'b0;
        for (int k = 0; k < 4; k++) send_sample(corner_sample(k));
        hold_sender();
    endtask

    // every window type on the shortest window, one sample past its end
    task automatic test_window_types();
        logic [TYPE_W-1:0] types [4];
        logic [CFG_DATA_W-1:0] tval;
        types = '{WT_FULL, WT_RISING, WT_FALLING, WT_UNUSED};
        for (int t = 0; t < 4; t++) begin
            tval = CFG_DATA_W'(types[t]);
            // upper data bits set on the unused code; they must be dropped
            if (types[t] == WT_UNUSED) tval = '1;
            configure(tval, CFG_DATA_W'(1));
            for (int k = 0; k < 5; k++) send_sample(corner_sample(k + t));
            hold_sender();
        end
    endtask

    // zero quads, then a write to an index with no register behind it
    task automatic test_quads_limits();
        configure(CFG_DATA_W'(WT_RISING), CFG_DATA_W'(0));
        for (int k = 0; k < 3; k++) send_sample(corner_sample(k + 2));
        hold_sender();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        for (int k = 0; k < 2; k++) send_sample(corner_sample(k + 5));
        hold_sender();
    endtask

    // random settings, mostly short windows, with single and paired writes
    task automatic test_random_windows();
        logic [CFG_DATA_W-1:0] tval, qval;
        int count;
        for (int ph = 0; ph < 8; ph++) begin
            tval = CFG_DATA_W'($urandom);
            tval[TYPE_W-1:0] = TYPE_W'($urandom_range(0, 3));
            qval = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                               : CFG_DATA_W'($urandom_range(0, 6));
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: write_reg(REG_WINDOW_TYPE, tval);
                1: write_reg(REG_WINDOW_QUADS, qval);
                default: configure(tval, qval);
            endcase
            count = $urandom_range(8, 30);
            for (int k = 0; k < count; k++) send_sample(draw_sample());
            hold_sender();
        end
    endtask

    // longest window, run once round and into the next
    task automatic test_long_window();
        configure(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'(MAX_QUADS));
        gaps_on = 1'b1;
        for (int k = 0; k < 4 * MAX_QUADS + 2; k++) send_sample(draw_sample());
        hold_sender();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_window_types();
        test_quads_limits();
        test_random_windows();
        test_long_window();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d samples and %0d window ends over %0d register writes,",
                 samples_seen, window_ends, reg_writes);
        $display("all window types, quads from zero to %0d, with stalls on both sides.",
                 MAX_QUADS);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/swo_pkg.sv
sv/swo_div.sv
sv/swo_cfg.sv
sv/swo_osc.sv
sv/swo_out.sv
sv/sine_window_oscillator_core.sv
tb/sv/sine_window_oscillator_core_tb.sv
